@@ hdl/jet_pkg.sv @@
// Package for the Julia set escape-time pixel block.
// Holds fixed-point widths, register indexes, payload structs, state type and helpers.
// No dependencies; imported by julia_escape_time_pixel.
package jet_pkg;

   localparam int FRACTION_BITS = 24;
   localparam int IMAGE_SIZE    = 512;
   // The image size is a power of two, so the coordinate scaling is a shift.
   localparam int IMAGE_BITS    = $clog2(IMAGE_SIZE);

   localparam int ROW_W   = 9;
   localparam int COUNT_W = 12;
   localparam int COEF_W  = 30;
   localparam int ZOOM_W  = 3;
   localparam int Z_W     = 32;
   localparam int PROD_W  = 2 * Z_W;
   // Width of a shifted product plus c, before saturation.
   localparam int SUM_W   = PROD_W + 2 - FRACTION_BITS;
   // Width of the signed start coordinate, before saturation.
   localparam int START_W = ROW_W + ZOOM_W + FRACTION_BITS + 2;

   localparam logic [PROD_W-1:0] ESCAPE_BOUND = PROD_W'(4) << (2 * FRACTION_BITS);

   localparam logic [COUNT_W-1:0] RAMP_LAST   = COUNT_W'(63);
   localparam logic [COUNT_W-1:0] GREEN_SATURATE = COUNT_W'(318);

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITERATION_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_C_REAL          = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_C_IMAG          = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZOOM_RATIO      = 2'd3;

   localparam logic [COUNT_W-1:0]       LIMIT_RESET  = COUNT_W'(256);
   localparam logic signed [COEF_W-1:0] C_REAL_RESET = COEF_W'(-13421773);
   localparam logic signed [COEF_W-1:0] C_IMAG_RESET = COEF_W'(2617246);
   localparam logic [ZOOM_W-1:0]        ZOOM_RESET   = ZOOM_W'(1);

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] column;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] iteration_count;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_MUL_XY,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Saturates a start coordinate to the signed 32-bit range.
   function automatic logic signed [Z_W-1:0] sat_start(input logic signed [START_W-1:0] v);
      logic [START_W-Z_W:0] top;
      top = v[START_W-1:Z_W-1];
      if (top == '0 || top == '1) begin
         return v[Z_W-1:0];
      end
      return v[START_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
   endfunction

   // Saturates an updated z part to the signed 32-bit range.
   function automatic logic signed [Z_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-Z_W:0] top;
      top = v[SUM_W-1:Z_W-1];
      if (top == '0 || top == '1) begin
         return v[Z_W-1:0];
      end
      return v[SUM_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
   endfunction

   // Maps a pixel index onto [-r, r) in fixed point: idx*2r/IMAGE_SIZE - r.
   function automatic logic signed [Z_W-1:0] start_coord(input logic [ROW_W-1:0] idx,
                                                         input logic [ZOOM_W-1:0] r);
      logic [ROW_W+ZOOM_W-1:0]               p;
      logic [ROW_W+ZOOM_W+FRACTION_BITS:0]   scaled;
      logic signed [START_W-1:0]             v;
      p      = (ROW_W+ZOOM_W)'(idx) * (ROW_W+ZOOM_W)'(r);
      scaled = {p, {(FRACTION_BITS+1){1'b0}}} >> IMAGE_BITS;
      v      = $signed({1'b0, scaled})
               - $signed({{(START_W-ZOOM_W-FRACTION_BITS){1'b0}}, r, {FRACTION_BITS{1'b0}}});
      return sat_start(v);
   endfunction

endpackage

@@ hdl/julia_escape_time_pixel.sv @@
// Julia set escape-time pixel engine: one shared 32x32 multiplier under a small sequencer.
// Depends on jet_pkg for widths, payload structs, register indexes and helpers.
//
// Usage:
//   The request channel (req_valid, req_stall, req_payload) carries a pixel's row and
//   column. A transaction completes when req_valid is high and req_stall is low.
//   The response channel (rsp_valid, rsp_stall, rsp_payload) returns the escape count
//   and an RGB color, one response per request, in order.
//   The csr channel writes iteration_limit, c_real, c_imag and zoom_ratio by index and is
//   always ready; the user must write it only while no pixel is in flight (not enforced).
// Sequencing:
//   Each iteration of z = z*z + c steps through ST_SQ_X, ST_SQ_Y, ST_MUL_XY and ST_UPDATE,
//   because the multiplier forms x*x, y*y and x*y in turn before the update state. The
//   work per pixel grows with its escape count, up to the limit (default 256). One pixel
//   is worked on at a time and req_stall is high from acceptance until its result is
//   handed to the output register.
// Reset:
//   reset is synchronous and active high; it loads the register defaults and empties
//   the pipeline. A stalled response holds its payload; the next result waits in the
//   sequencer until the output register frees up.
module julia_escape_time_pixel
   import jet_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_data
);

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]       limit_ff;
   logic signed [COEF_W-1:0] c_re_ff, c_im_ff;
   logic [ZOOM_W-1:0]        zoom_ff;

   logic signed [Z_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [PROD_W-1:0] xx_ff, yy_ff, xy_ff;
   logic [COUNT_W-1:0]       n_ff, n_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_ff, rsp_in;

   logic signed [Z_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0] product;
   logic [PROD_W-1:0]        mag_sum;
   logic                     escaped;
   logic signed [PROD_W:0]   diff;
   logic signed [SUM_W-1:0]  re_sum, im_sum;
   rsp_payload_type          color;

   assign csr_ready   = 1'b1;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         c_re_ff  <= C_REAL_RESET;
         c_im_ff  <= C_IMAG_RESET;
         zoom_ff  <= ZOOM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ITERATION_LIMIT: limit_ff <= csr_data[COUNT_W-1:0];
            CSR_C_REAL:          c_re_ff  <= csr_data;
            CSR_C_IMAG:          c_im_ff  <= csr_data;
            CSR_ZOOM_RATIO:      zoom_ff  <= csr_data[ZOOM_W-1:0];
            default: ;
         endcase
      end
   end

   // The one multiplier; operands follow the sequencer state.
   always_comb begin
      unique case (state_ff)
         ST_SQ_Y:   begin mul_a = y_ff; mul_b = y_ff; end
         ST_MUL_XY: begin mul_a = x_ff; mul_b = y_ff; end
         default:   begin mul_a = x_ff; mul_b = x_ff; end
      endcase
   end
   assign product = mul_a * mul_b;

   // Squares are never negative and at most 2**62, so the low 63 bits hold them exactly.
   assign mag_sum = {1'b0, xx_ff[PROD_W-2:0]} + {1'b0, yy_ff[PROD_W-2:0]};
   assign escaped = (mag_sum > ESCAPE_BOUND);

   // Arithmetic right shifts round toward minus infinity; 2xy >> F equals xy >> (F-1).
   assign diff   = {xx_ff[PROD_W-1], xx_ff} - {yy_ff[PROD_W-1], yy_ff};
   assign re_sum = $signed({diff[PROD_W], diff[PROD_W:FRACTION_BITS]})
                   + SUM_W'(c_re_ff);
   assign im_sum = $signed({xy_ff[PROD_W-1], xy_ff[PROD_W-1:FRACTION_BITS-1]})
                   + SUM_W'(c_im_ff);

   // Color mapping of the final count.
   always_comb begin
      color.iteration_count = n_ff;
      color.red             = 8'hFF;
      priority if (n_ff == limit_ff) begin
         color.green = 8'hFF;
         color.blue  = 8'hFF;
      end else if (n_ff <= RAMP_LAST) begin
         color.green = 8'hFF - {n_ff[5:0], 2'b00};
         color.blue  = 8'hFF - {n_ff[5:0], 2'b00};
      end else if (n_ff > GREEN_SATURATE) begin
         color.green = 8'hFF;
         color.blue  = 8'h00;
      end else begin
         color.green = 8'(n_ff - RAMP_LAST);
         color.blue  = 8'h00;
      end
   end

   // Sequencer: next state and datapath register loads.
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      n_in         = n_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = start_coord(req_payload.row, zoom_ff);
               y_in     = start_coord(req_payload.column, zoom_ff);
               n_in     = '0;
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            state_in = ST_MUL_XY;
         end
         ST_MUL_XY: begin
            // The start value is not tested; each updated z is tested on its squares.
            if ((n_ff != '0 && escaped) || n_ff == limit_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            x_in     = sat_sum(re_sum);
            y_in     = sat_sum(im_sum);
            n_in     = n_ff + COUNT_W'(1);
            state_in = ST_SQ_X;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = color;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      n_ff   <= n_in;
      rsp_ff <= rsp_in;
      if (state_ff == ST_SQ_X) begin
         xx_ff <= product;
      end
      if (state_ff == ST_SQ_Y) begin
         yy_ff <= product;
      end
      if (state_ff == ST_MUL_XY) begin
         xy_ff <= product;
      end
   end

endmodule
